/* rtl/ppim_pkg.sv */
// ----------------------------------------------------------------------------
// ppim_pkg
// Shared constants, register codes, sideband type and arctangent table for
// the polar pad index mapper.
// ----------------------------------------------------------------------------
package ppim_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD_BITS       = 16;
  localparam int COUNT_BITS       = 9;
  localparam int RADIUS_BITS      = 16;
  localparam int PAD_BITS         = 16;
  localparam int CFG_IDX_BITS     = 2;

  // 1/K of the CORDIC gain as a 32-bit fraction
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RINGS   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SECTORS = 2'd3;

  typedef struct packed {
    logic                      outside;
    logic [2*COUNT_BITS-1:0]   base;
  } ppim_side_t;

  // atan(2^-i) as a fraction of a turn, 32-bit
  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] v;
    case (step)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
      16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;
      20: v = 32'h0000028C;  21: v = 32'h00000146;
      22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;
      26: v = 32'h0000000A;  27: v = 32'h00000005;
      28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* rtl/polar_pad_index_mapper.sv */
// Throughput: one hit per cycle; busy is always low.
// The depth is set by the CORDIC cell chain plus the nine-cell ring divider.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
//   window registers to inner 0, outer 65535, one ring, one sector.
// ----------------------------------------------------------------------------
// polar_pad_index_mapper
// Maps a hit (x, y) to a pad of a ring/sector station via a CORDIC chain
// and a pipelined ring divider.
// ----------------------------------------------------------------------------
module polar_pad_index_mapper #(
  parameter int COORD_BITS   = ppim_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = ppim_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      in_hit_x,
  input  logic signed [COORD_BITS-1:0]      in_hit_y,
  output logic                              out_valid,
  output logic [ppim_pkg::PAD_BITS-1:0]     out_pad_number,
  output logic                              out_outside_window,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppim_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ppim_pkg::RADIUS_BITS-1:0]  cfg_data
);
  import ppim_pkg::*;

  localparam int XW = COORD_BITS + GUARD_BITS + 3;
  localparam int CW = ((XW > 32) ? XW : 32) + 1;
  localparam int NW = 32 + COUNT_BITS;
  localparam int BW = 2 * COUNT_BITS;

  // configuration
  logic [RADIUS_BITS-1:0] inner_r, outer_r;
  logic [COUNT_BITS-1:0]  rings_r, sectors_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r   <= '0;
      outer_r   <= '1;
      rings_r   <= COUNT_BITS'(1);
      sectors_r <= COUNT_BITS'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INNER:   inner_r   <= cfg_data;
        CFG_OUTER:   outer_r   <= cfg_data;
        CFG_RINGS:   rings_r   <= cfg_data[COUNT_BITS-1:0];
        CFG_SECTORS: sectors_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front end: fold left half-plane, scale in guard bits
  logic signed [XW-1:0] xe, ye, x0_nxt, y0_nxt;
  logic [31:0]          z0_nxt;
  logic                 org_nxt;

  assign xe = XW'(in_hit_x);
  assign ye = XW'(in_hit_y);

  always_comb begin
    org_nxt = (in_hit_x == '0) && (in_hit_y == '0);
    if (in_hit_x[COORD_BITS-1]) begin
      x0_nxt = (-xe) <<< GUARD_BITS;
      y0_nxt = (-ye) <<< GUARD_BITS;
      z0_nxt = HALF_TURN;
    end else begin
      x0_nxt = xe <<< GUARD_BITS;
      y0_nxt = ye <<< GUARD_BITS;
      z0_nxt = '0;
    end
  end

  logic                 cv [0:CORDIC_STEPS];
  logic signed [XW-1:0] cx [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy [0:CORDIC_STEPS];
  logic [31:0]          cz [0:CORDIC_STEPS];
  logic                 co [0:CORDIC_STEPS];

  logic                 v0_r;
  logic signed [XW-1:0] x0_r, y0_r;
  logic [31:0]          z0_r;
  logic                 org0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    z0_r   <= z0_nxt;
    org0_r <= org_nxt;
  end

  assign cv[0] = v0_r;
  assign cx[0] = x0_r;
  assign cy[0] = y0_r;
  assign cz[0] = z0_r;
  assign co[0] = org0_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    ppim_cordic_cell #(.XW(XW), .STEP(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .origin_i(co[i]),
      .valid_o (cv[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .origin_o(co[i+1])
    );
  end

  // gain removal, split product
  logic [XW-1:0]    xu;
  logic [XW-17:0]   xh;
  logic             v1_r;
  logic [XW+15:0]   phi_r, phi_nxt;
  logic [47:0]      plo_r, plo_nxt;
  logic [15:0]      ang_r, ang_nxt;

  assign xu      = cx[CORDIC_STEPS];
  assign xh      = xu[XW-1:16];
  assign phi_nxt = (XW+16)'(xh) * (XW+16)'(INV_GAIN);
  assign plo_nxt = 48'(xu[15:0]) * 48'(INV_GAIN);
  assign ang_nxt = co[CORDIC_STEPS] ? 16'h0 : cz[CORDIC_STEPS][31:16];

  // radius and sector product
  logic             v2_r;
  logic [XW+32:0]   psum;
  logic [XW-1:0]    rq_r, rq_nxt;
  logic [24:0]      sprod_r, sprod_nxt;

  assign psum      = ((XW+33)'(phi_r) << 16) + (XW+33)'(plo_r);
  assign rq_nxt    = psum[XW+31:32];
  assign sprod_nxt = 25'(ang_r) * 25'(sectors_r);

  // window test, ring numerator, pad base
  logic             v3_r;
  logic [CW-1:0]    rqz, loz, hiz;
  logic [31:0]      diff, den_nxt;
  logic [NW-1:0]    num_nxt;
  ppim_side_t       side_nxt;

  assign rqz  = CW'(rq_r);
  assign loz  = CW'({inner_r, 16'h0});
  assign hiz  = CW'({outer_r, 16'h0});
  assign diff = 32'(rqz - loz);
  assign num_nxt = NW'(diff) * NW'(rings_r);
  assign den_nxt = {outer_r, 16'h0} - {inner_r, 16'h0};
  assign side_nxt.outside = (rqz < loz) || (rqz >= hiz);
  assign side_nxt.base    = BW'(sprod_r[24:16]) * BW'(rings_r);

  logic [NW-1:0] num_r;
  logic [31:0]   den_r;
  ppim_side_t    side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cv[CORDIC_STEPS];
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    phi_r   <= phi_nxt;
    plo_r   <= plo_nxt;
    ang_r   <= ang_nxt;
    rq_r    <= rq_nxt;
    sprod_r <= sprod_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    side_r  <= side_nxt;
  end

  // ring divider: quotient below 2^COUNT_BITS, one bit per cell, MSB first
  logic                  dv [0:COUNT_BITS];
  logic [NW-1:0]         dr [0:COUNT_BITS];
  logic [31:0]           dd [0:COUNT_BITS];
  logic [COUNT_BITS-1:0] dq [0:COUNT_BITS];
  ppim_side_t            ds [0:COUNT_BITS];

  assign dv[0] = v3_r;
  assign dr[0] = num_r;
  assign dd[0] = den_r;
  assign dq[0] = '0;
  assign ds[0] = side_r;

  for (genvar k = 0; k < COUNT_BITS; k++) begin : g_div
    ppim_div_cell #(.NW(NW), .SHIFT(COUNT_BITS-1-k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(dv[k]),
      .rem_i  (dr[k]),
      .den_i  (dd[k]),
      .q_i    (dq[k]),
      .side_i (ds[k]),
      .valid_o(dv[k+1]),
      .rem_o  (dr[k+1]),
      .den_o  (dd[k+1]),
      .q_o    (dq[k+1]),
      .side_o (ds[k+1])
    );
  end

  // output register
  logic                vo_r;
  logic [PAD_BITS-1:0] pad_r, pad_nxt;
  logic                out_r;
  logic [BW-1:0]       pad_full;

  assign pad_full = ds[COUNT_BITS].base + BW'(dq[COUNT_BITS]);
  assign pad_nxt  = ds[COUNT_BITS].outside ? '0 : PAD_BITS'(pad_full);

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else        vo_r <= dv[COUNT_BITS];
  end

  always_ff @(posedge clk) begin
    pad_r <= pad_nxt;
    out_r <= ds[COUNT_BITS].outside;
  end

  assign out_valid          = vo_r;
  assign out_pad_number     = pad_r;
  assign out_outside_window = out_r;

endmodule

/* rtl/ppim_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ppim_cordic_cell
// One registered CORDIC vectoring micro-rotation, fixed shift per cell.
// ----------------------------------------------------------------------------
module ppim_cordic_cell #(
  parameter int XW   = 35,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          z_i,
  input  logic                 origin_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [31:0]          z_o,
  output logic                 origin_o
);
  import ppim_pkg::*;

  localparam logic [31:0] ATAN = atan_turn(STEP);

  logic                 valid_r;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic [31:0]          z_r, z_nxt;
  logic                 origin_r;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    origin_r <= origin_i;
  end

  assign valid_o  = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign z_o      = z_r;
  assign origin_o = origin_r;

endmodule

/* rtl/ppim_div_cell.sv */
// ----------------------------------------------------------------------------
// ppim_div_cell
// One registered restoring-division step that resolves one quotient bit.
// ----------------------------------------------------------------------------
module ppim_div_cell #(
  parameter int NW    = 41,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [NW-1:0]                 rem_i,
  input  logic [31:0]                   den_i,
  input  logic [ppim_pkg::COUNT_BITS-1:0] q_i,
  input  ppim_pkg::ppim_side_t          side_i,
  output logic                          valid_o,
  output logic [NW-1:0]                 rem_o,
  output logic [31:0]                   den_o,
  output logic [ppim_pkg::COUNT_BITS-1:0] q_o,
  output ppim_pkg::ppim_side_t          side_o
);
  import ppim_pkg::*;

  logic                  valid_r;
  logic [NW-1:0]         rem_r, rem_nxt, dsh;
  logic [31:0]           den_r;
  logic [COUNT_BITS-1:0] q_r, q_nxt;
  ppim_side_t            side_r;

  assign dsh = NW'(den_i) << SHIFT;

  always_comb begin
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= dsh) begin
      rem_nxt = rem_i - dsh;
      q_nxt   = q_i | (COUNT_BITS'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_i;
    q_r    <= q_nxt;
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign q_o     = q_r;
  assign side_o  = side_r;

endmodule
